### hw/rtl/sfr_pkg.sv
package sfr_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int SIZE_W    = 11;                  // size register width
	localparam int COL_W     = $clog2(MAX_WIDTH);   // column counter / line store address
	localparam int ROW_W     = SIZE_W;              // row counter runs to height + 1
	localparam int CFG_IDX_W = 2;
	localparam int CHAN_W    = 8;
	localparam int SUM_W     = 12;                  // holds 9 * 255 and 10 * 255

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(600);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(400);

	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	// [2] red, [1] green, [0] blue
	typedef logic [2:0][CHAN_W-1:0] rgb_t;

	typedef struct packed {
		logic              cmd;
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic              frame_end;
	} res_t;

	// one window column, top row first
	typedef struct packed {
		rgb_t top;
		rgb_t mid;
		rgb_t bot;
	} col_t;

	typedef struct packed {
		rgb_t upper;
		rgb_t middle;
	} line_t;

	typedef struct packed {
		logic valid;   // item updates line stores and window
		logic emit;    // item yields a result
		logic last;    // result closes the frame
		logic pass;    // border pixel, center goes out unchanged
	} ctl_t;

endpackage

### hw/rtl/sharpen_filter_3x3_rgb_top.sv
// channel | signals                          | beat taken when
// --------+----------------------------------+-----------------------
// pixel   | pix_valid, pix_stall, pix        | pix_valid && !pix_stall
// result  | res_valid, res_stall, res        | res_valid && !res_stall
// config  | cfg_valid, cfg_ready, cfg_index, | cfg_valid && cfg_ready
//         | cfg_data                         |
//
// pix_stall is high while a result waits under res_stall; otherwise one pixel beat per
// clock. A taken beat's result passes the line store read on the taking edge, window
// column chain, sum stage and output register. Results lag the input by one row plus
// one pixel; W+1 drain beats close a frame. Reset: size 600 x 400, positions and window
// zero; line stores are not cleared. Stages advance together, the window on valid items.
module sharpen_filter_3x3_rgb_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  sfr_pkg::pix_t                 pix,
	output logic                          res_valid,
	input  logic                          res_stall,
	output sfr_pkg::res_t                 res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::SIZE_W-1:0]    cfg_data
);
	import sfr_pkg::*;

	localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

	logic [SIZE_W-1:0] w_q;
	logic [SIZE_W-1:0] h_q;
	logic [COL_W-1:0]  ic_q;
	logic [ROW_W-1:0]  ir_q;

	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_w;
	logic [SIZE_W-1:0] cfg_h;
	logic              adv;
	logic              acc;
	logic              tail;
	logic              drop;
	logic              take;
	logic              at_end;
	logic              col_last;
	logic              emit;
	logic              pass;

	ctl_t              ctl_s1;
	ctl_t              ctl_s2;
	rgb_t              px_s1;
	logic [COL_W-1:0]  addr_s1;
	line_t             rd_line;
	line_t             wr_line;
	logic              win_en;
	col_t              col_new;
	col_t              col_r;
	col_t              col_c;
	col_t              col_l;
	logic              calc_valid;
	res_t              calc_res;
	logic              res_valid_q;
	res_t              res_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign cfg_w = (cfg_data < MIN_SIZE) ? MIN_SIZE : ((cfg_data > MAX_W_SZ) ? MAX_W_SZ : cfg_data);
	assign cfg_h = (cfg_data < MIN_SIZE) ? MIN_SIZE : ((cfg_data > MAX_H_SZ) ? MAX_H_SZ : cfg_data);

	assign adv       = !res_valid_q || !res_stall;
	assign pix_stall = !adv;
	assign acc       = pix_valid && adv;

	// past the last row every beat is a drain; inside the frame a drain is dropped
	assign tail     = ir_q >= h_q;
	assign drop     = !tail && pix.cmd;
	assign take     = acc && !drop;
	assign at_end   = (ir_q == h_q + SIZE_W'(1)) && (ic_q == '0);
	assign col_last = (SIZE_W'(ic_q) + SIZE_W'(1)) == w_q;
	assign emit     = (ir_q >= ROW_W'(2)) || ((ir_q == ROW_W'(1)) && (ic_q != '0));
	// column 0 beat returns the previous row's last pixel, always a border pixel
	assign pass     = (ic_q == '0) || (ic_q == COL_W'(1)) || (ir_q == ROW_W'(1)) || (ir_q == h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= WIDTH_RESET;
			h_q  <= HEIGHT_RESET;
			ic_q <= '0;
			ir_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) begin
				w_q  <= cfg_w;
				ic_q <= '0;
				ir_q <= '0;
			end else if (cfg_index == REG_HEIGHT) begin
				h_q  <= cfg_h;
				ic_q <= '0;
				ir_q <= '0;
			end
		end else if (take) begin
			if (at_end) begin
				ic_q <= '0;
				ir_q <= '0;
			end else if (col_last) begin
				ic_q <= '0;
				ir_q <= ir_q + ROW_W'(1);
			end else begin
				ic_q <= ic_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= take;
			ctl_s1.emit  <= emit;
			ctl_s1.last  <= at_end;
			ctl_s1.pass  <= pass;
			ctl_s2       <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1   <= tail ? '0 : {pix.red_in, pix.green_in, pix.blue_in};
			addr_s1 <= ic_q;
		end
	end

	assign win_en         = adv && ctl_s1.valid;
	assign wr_line.upper  = rd_line.middle;
	assign wr_line.middle = px_s1;
	assign col_new.top    = rd_line.upper;
	assign col_new.mid    = rd_line.middle;
	assign col_new.bot    = px_s1;

	sfr_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (ic_q),
		.rd_data (rd_line),
		.wr_en   (win_en),
		.wr_addr (addr_s1),
		.wr_data (wr_line)
	);

	sfr_col_cell u_cell_r (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (win_en),
		.col_in (col_new),
		.col_q  (col_r)
	);

	sfr_col_cell u_cell_c (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (win_en),
		.col_in (col_r),
		.col_q  (col_c)
	);

	sfr_col_cell u_cell_l (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (win_en),
		.col_in (col_c),
		.col_q  (col_l)
	);

	sfr_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s2    (ctl_s2),
		.left      (col_l),
		.center    (col_c),
		.right     (col_r),
		.out_valid (calc_valid),
		.result    (calc_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= calc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= calc_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ir_q <= h_q + SIZE_W'(1))
		else $error("row counter past drain row");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SIZE_W'(ic_q) < w_q)
		else $error("column counter past row width");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		w_q >= MIN_SIZE && w_q <= MAX_W_SZ && h_q >= MIN_SIZE && h_q <= MAX_H_SZ)
		else $error("frame size out of range");

	a_end_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		take && at_end |=> ic_q == '0 && ir_q == '0)
		else $error("position not restarted after frame end");

	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && drop && !cfg_we |=> $stable(ic_q) && $stable(ir_q))
		else $error("dropped drain beat moved the position");

endmodule

### hw/rtl/sfr_line_buf.sv
module sfr_line_buf (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [sfr_pkg::COL_W-1:0] rd_addr,
	output sfr_pkg::line_t            rd_data,
	input  logic                      wr_en,
	input  logic [sfr_pkg::COL_W-1:0] wr_addr,
	input  sfr_pkg::line_t            wr_data
);
	import sfr_pkg::*;

	line_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/sfr_col_cell.sv
module sfr_col_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  sfr_pkg::col_t col_in,
	output sfr_pkg::col_t col_q
);
	import sfr_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (en) begin
			col_q <= col_in;
		end
	end

endmodule

### hw/rtl/sfr_calc.sv
module sfr_calc (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  sfr_pkg::ctl_t ctl_s2,
	input  sfr_pkg::col_t left,
	input  sfr_pkg::col_t center,
	input  sfr_pkg::col_t right,
	output logic          out_valid,
	output sfr_pkg::res_t result
);
	import sfr_pkg::*;

	logic [2:0][SUM_W-1:0] sum9;
	logic [2:0][SUM_W-1:0] c10;
	logic [2:0][SUM_W-1:0] sum_s3;
	logic [2:0][SUM_W-1:0] c10_s3;
	rgb_t                  ctr_s3;
	ctl_t                  ctl_s3;
	logic [2:0][SUM_W:0]   diff;
	rgb_t                  sharp;
	rgb_t                  pix_o;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum9[ch] = SUM_W'(left.top[ch]) + SUM_W'(left.mid[ch]) + SUM_W'(left.bot[ch])
				+ SUM_W'(center.top[ch]) + SUM_W'(center.mid[ch]) + SUM_W'(center.bot[ch])
				+ SUM_W'(right.top[ch]) + SUM_W'(right.mid[ch]) + SUM_W'(right.bot[ch]);
			c10[ch] = (SUM_W'(center.mid[ch]) << 3) + (SUM_W'(center.mid[ch]) << 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sum9;
			c10_s3 <= c10;
			ctr_s3 <= center.mid;
		end
	end

	// 10*c - sum, clamped to the channel range
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			diff[ch] = {1'b0, c10_s3[ch]} - {1'b0, sum_s3[ch]};
			if (diff[ch][SUM_W]) begin
				sharp[ch] = '0;
			end else if (|diff[ch][SUM_W-1:CHAN_W]) begin
				sharp[ch] = CHAN_MAX;
			end else begin
				sharp[ch] = diff[ch][CHAN_W-1:0];
			end
		end
		pix_o = ctl_s3.pass ? ctr_s3 : sharp;
	end

	assign out_valid        = ctl_s3.valid && ctl_s3.emit;
	assign result.red_out   = pix_o[2];
	assign result.green_out = pix_o[1];
	assign result.blue_out  = pix_o[0];
	assign result.frame_end = ctl_s3.last;

endmodule
